// ===== rtl/hwfft_pkg.sv =====
// Shared types, constants and twiddle functions for the windowed FFT frame block.
// No dependencies.
package hwfft_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int DATA_BITS       = 24;
   localparam int BINS_PER_RESULT = 4;
   localparam int PAIRS           = BINS_PER_RESULT / 2;
   localparam int PAIR_BITS       = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int ADDR_BITS       = 8;
   localparam int HOP_BITS        = 9;

   localparam logic signed [15:0] HAM_A = 16'sd17695;
   localparam logic signed [15:0] HAM_B = 16'sd15073;

   localparam logic signed [15:0] QUARTER_COS [0:64] = '{
      16'sd32767, 16'sd32758, 16'sd32729, 16'sd32679, 16'sd32610, 16'sd32522, 16'sd32413,
      16'sd32286, 16'sd32138, 16'sd31972, 16'sd31786, 16'sd31581, 16'sd31357, 16'sd31114,
      16'sd30853, 16'sd30572, 16'sd30274, 16'sd29957, 16'sd29622, 16'sd29269, 16'sd28899,
      16'sd28511, 16'sd28106, 16'sd27684, 16'sd27246, 16'sd26791, 16'sd26320, 16'sd25833,
      16'sd25330, 16'sd24812, 16'sd24279, 16'sd23732, 16'sd23170, 16'sd22595, 16'sd22006,
      16'sd21403, 16'sd20788, 16'sd20160, 16'sd19520, 16'sd18868, 16'sd18205, 16'sd17531,
      16'sd16846, 16'sd16151, 16'sd15447, 16'sd14733, 16'sd14010, 16'sd13279, 16'sd12540,
      16'sd11793, 16'sd11039, 16'sd10279, 16'sd9512, 16'sd8740, 16'sd7962, 16'sd7180,
      16'sd6393, 16'sd5602, 16'sd4808, 16'sd4011, 16'sd3212, 16'sd2411, 16'sd1608,
      16'sd804, 16'sd0
   };

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          restart;
   } req_type;

   typedef struct packed {
      logic [7:0]                  bin_base;
      logic signed [DATA_BITS-1:0] re0;
      logic signed [DATA_BITS-1:0] im0;
      logic signed [DATA_BITS-1:0] re1;
      logic signed [DATA_BITS-1:0] im1;
      logic signed [DATA_BITS-1:0] re2;
      logic signed [DATA_BITS-1:0] im2;
      logic signed [DATA_BITS-1:0] re3;
      logic signed [DATA_BITS-1:0] im3;
      logic                        last_group;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LD_RD,
      OP_LD_MUL1,
      OP_LD_H,
      OP_LD_MUL2,
      OP_LD_WR,
      OP_BF_RD,
      OP_BF_MUL,
      OP_BF_SUM,
      OP_BF_WA,
      OP_BF_WC,
      OP_OUT_RD,
      OP_OUT_CAP
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   ring_wr;
      logic [ADDR_BITS-1:0]   ring_addr;
      logic [ADDR_BITS-1:0]   a_addr;
      logic [ADDR_BITS-1:0]   c_addr;
      logic [7:0]             tw;
      logic [PAIR_BITS-1:0]   pair;
      logic [7:0]             bin_base;
      logic                   last_group;
   } cmd_type;

   function automatic logic signed [15:0] cos_at(input logic [7:0] m);
      logic [7:0] d;
      d = 8'd0;
      if (m <= 8'd64) begin
         return QUARTER_COS[m[6:0]];
      end else if (m <= 8'd128) begin
         d = 8'd128 - m;
         return -QUARTER_COS[d[6:0]];
      end else if (m <= 8'd192) begin
         d = m - 8'd128;
         return -QUARTER_COS[d[6:0]];
      end else begin
         d = 8'd0 - m;
         return QUARTER_COS[d[6:0]];
      end
   endfunction

   function automatic logic signed [15:0] sin_at(input logic [7:0] m);
      return cos_at(m + 8'd192);
   endfunction

endpackage

// ===== rtl/hwfft_datapath.sv =====
// Datapath: sample ring, work memory, Hamming multiply and the shared butterfly.
// Depends on hwfft_pkg; driven by commands from hwfft_ctrl.
module hwfft_datapath import hwfft_pkg::*; #(
   parameter int FRAME_POINTS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output rsp_type rsp_payload
);

   localparam int AW = $clog2(FRAME_POINTS);

   logic signed [SAMPLE_BITS-1:0]   ring_mem [FRAME_POINTS];
   logic [2*DATA_BITS-1:0]          work_mem [FRAME_POINTS];

   logic signed [SAMPLE_BITS-1:0]   ring_q_ff;
   logic [2*DATA_BITS-1:0]          rd_a_ff, rd_c_ff;
   logic signed [SAMPLE_BITS-1:0]   src_ff;
   logic signed [31:0]              hprod_ff;
   logic signed [16:0]              h_ff;
   logic signed [33:0]              wprod_ff;
   logic signed [DATA_BITS-1:0]     a_re_ff, a_im_ff;
   logic signed [40:0]              p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [26:0]              tr_ff, ti_ff;
   logic signed [DATA_BITS-1:0]     bin_re_ff [BINS_PER_RESULT];
   logic signed [DATA_BITS-1:0]     bin_im_ff [BINS_PER_RESULT];
   logic [7:0]                      bin_base_ff;
   logic                            last_ff;

   logic signed [15:0]              cos_v, wr_v, wi_v;
   logic signed [DATA_BITS-1:0]     c_re_v, c_im_v;
   logic signed [31:0]              hprod_in;
   logic signed [16:0]              hr_v, h_in;
   logic signed [DATA_BITS-1:0]     win_v;
   logic signed [41:0]              tr_full, ti_full;
   logic signed [DATA_BITS-1:0]     sum_re, sum_im, dif_re, dif_im;
   logic [AW-1:0]                   wr_addr;
   logic [2*DATA_BITS-1:0]          wr_data;
   logic                            wr_en;
   logic [PAIR_BITS:0]              bin_idx;

   function automatic logic signed [DATA_BITS-1:0] sat24(input logic signed [27:0] v);
      if (v > 28'sd8388607) return 24'sh7fffff;
      if (v < -28'sd8388608) return 24'sh800000;
      return v[DATA_BITS-1:0];
   endfunction

   always_comb begin
      cos_v    = cos_at(cmd.tw);
      wr_v     = cos_v;
      wi_v     = -sin_at(cmd.tw);
      c_re_v   = rd_c_ff[2*DATA_BITS-1:DATA_BITS];
      c_im_v   = rd_c_ff[DATA_BITS-1:0];
      hprod_in = 32'(HAM_B) * 32'(cos_v);
      hr_v     = 17'((hprod_ff + 32'sd16384) >>> 15);
      h_in     = 17'(HAM_A) - hr_v;
      if (h_in > 17'sd32767) h_in = 17'sd32767;
      win_v    = 24'((wprod_ff + 34'sd16384) >>> 15);
      tr_full  = 42'(p_rr_ff) - 42'(p_ii_ff) + 42'sd16384;
      ti_full  = 42'(p_ri_ff) + 42'(p_ir_ff) + 42'sd16384;
      sum_re   = sat24(28'(a_re_ff) + 28'(tr_ff));
      sum_im   = sat24(28'(a_im_ff) + 28'(ti_ff));
      dif_re   = sat24(28'(a_re_ff) - 28'(tr_ff));
      dif_im   = sat24(28'(a_im_ff) - 28'(ti_ff));
      bin_idx  = {cmd.pair, 1'b0};
      wr_en    = 1'b0;
      wr_addr  = cmd.a_addr[AW-1:0];
      wr_data  = {sum_re, sum_im};
      case (cmd.op)
         OP_LD_WR: begin
            wr_en   = 1'b1;
            wr_data = {win_v, {DATA_BITS{1'b0}}};
         end
         OP_BF_WA: wr_en = 1'b1;
         OP_BF_WC: begin
            wr_en   = 1'b1;
            wr_addr = cmd.c_addr[AW-1:0];
            wr_data = {dif_re, dif_im};
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.ring_wr) ring_mem[cmd.ring_addr[AW-1:0]] <= sample;
      ring_q_ff <= ring_mem[cmd.ring_addr[AW-1:0]];
      if (wr_en) work_mem[wr_addr] <= wr_data;
      rd_a_ff <= work_mem[cmd.a_addr[AW-1:0]];
      rd_c_ff <= work_mem[cmd.c_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LD_MUL1: begin
            src_ff   <= ring_q_ff;
            hprod_ff <= hprod_in;
         end
         OP_LD_H:    h_ff     <= h_in;
         OP_LD_MUL2: wprod_ff <= 34'(src_ff) * 34'(h_ff);
         OP_BF_MUL: begin
            a_re_ff <= rd_a_ff[2*DATA_BITS-1:DATA_BITS];
            a_im_ff <= rd_a_ff[DATA_BITS-1:0];
            p_rr_ff <= 41'(wr_v) * 41'(c_re_v);
            p_ii_ff <= 41'(wi_v) * 41'(c_im_v);
            p_ri_ff <= 41'(wr_v) * 41'(c_im_v);
            p_ir_ff <= 41'(wi_v) * 41'(c_re_v);
         end
         OP_BF_SUM: begin
            tr_ff <= 27'(tr_full >>> 15);
            ti_ff <= 27'(ti_full >>> 15);
         end
         OP_OUT_CAP: begin
            bin_re_ff[bin_idx]      <= rd_a_ff[2*DATA_BITS-1:DATA_BITS];
            bin_im_ff[bin_idx]      <= rd_a_ff[DATA_BITS-1:0];
            bin_re_ff[bin_idx + 1'b1] <= rd_c_ff[2*DATA_BITS-1:DATA_BITS];
            bin_im_ff[bin_idx + 1'b1] <= rd_c_ff[DATA_BITS-1:0];
            bin_base_ff <= cmd.bin_base;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) last_ff <= 1'b0;
      else if (cmd.op == OP_OUT_CAP) last_ff <= cmd.last_group;
   end

   assign rsp_payload = '{bin_base: bin_base_ff,
                          re0: bin_re_ff[0], im0: bin_im_ff[0],
                          re1: bin_re_ff[1], im1: bin_im_ff[1],
                          re2: bin_re_ff[2], im2: bin_im_ff[2],
                          re3: bin_re_ff[3], im3: bin_im_ff[3],
                          last_group: last_ff};

endmodule

// ===== rtl/hwfft_ctrl.sv =====
// Controller: fill and hop tracking, hop register, and the frame sequencer.
// Depends on hwfft_pkg; issues commands to hwfft_datapath.
module hwfft_ctrl import hwfft_pkg::*; #(
   parameter int FRAME_POINTS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_restart,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                csr_wr_en,
   input  logic [HOP_BITS-1:0] csr_wr_data,
   output cmd_type             cmd
);

   localparam int AW     = $clog2(FRAME_POINTS);
   localparam int SW     = $clog2(AW);
   localparam int FW     = $clog2(FRAME_POINTS + 1);
   localparam int GW     = AW - 2;
   localparam int GROUPS = FRAME_POINTS / BINS_PER_RESULT;

   typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_BFLY, ST_OREAD, ST_OSHOW} state_type;

   state_type           state_ff;
   logic [2:0]          sub_ff;
   logic [AW-1:0]       cnt_ff;
   logic [SW-1:0]       stage_ff;
   logic [AW-1:0]       wp_ff;
   logic [FW-1:0]       fill_ff;
   logic [HOP_BITS-1:0] hop_ff, hop_len_ff;

   logic                accept, go;
   logic [FW-1:0]       fill_v, fill_in;
   logic [HOP_BITS-1:0] hop_v, hop_in, hop_inc;
   logic [AW-1:0]       half_v, k_v, a_bf, rev_v, a_out;
   logic [PAIR_BITS-1:0] pair_v;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OSHOW);

   always_comb begin
      fill_v  = req_restart ? '0 : fill_ff;
      hop_v   = req_restart ? '0 : hop_ff;
      hop_inc = hop_v + 1'b1;
      go      = 1'b0;
      fill_in = fill_v;
      hop_in  = hop_v;
      if (fill_v < FW'(FRAME_POINTS)) begin
         fill_in = fill_v + 1'b1;
         if (fill_in == FW'(FRAME_POINTS)) begin
            go     = 1'b1;
            hop_in = '0;
         end
      end else if (hop_inc >= hop_len_ff) begin
         go     = 1'b1;
         hop_in = '0;
      end else begin
         hop_in = hop_inc;
      end
   end

   always_comb begin
      half_v = AW'(1) << stage_ff;
      k_v    = cnt_ff & (half_v - 1'b1);
      a_bf   = ((cnt_ff >> stage_ff) << (stage_ff + 1'b1)) | k_v;
      for (int t = 0; t < AW; t++) rev_v[t] = cnt_ff[AW-1-t];
      pair_v = sub_ff[PAIR_BITS:1];
      a_out  = {cnt_ff[GW-1:0], pair_v, 1'b0};

      cmd            = '0;
      cmd.op         = OP_NONE;
      cmd.ring_wr    = accept;
      cmd.ring_addr  = ADDR_BITS'(wp_ff);
      cmd.pair       = pair_v;
      cmd.bin_base   = 8'({cnt_ff[GW-1:0], 2'b00});
      cmd.last_group = (cnt_ff == AW'(GROUPS - 1));
      unique case (state_ff)
         ST_IDLE: cmd.op = OP_NONE;
         ST_LOAD: begin
            cmd.ring_addr = ADDR_BITS'(wp_ff + cnt_ff);
            cmd.a_addr    = ADDR_BITS'(rev_v);
            cmd.tw        = 8'(8'(cnt_ff) << (8 - AW));
            unique case (sub_ff)
               3'd0:    cmd.op = OP_LD_RD;
               3'd1:    cmd.op = OP_LD_MUL1;
               3'd2:    cmd.op = OP_LD_H;
               3'd3:    cmd.op = OP_LD_MUL2;
               default: cmd.op = OP_LD_WR;
            endcase
         end
         ST_BFLY: begin
            cmd.a_addr = ADDR_BITS'(a_bf);
            cmd.c_addr = ADDR_BITS'(a_bf | half_v);
            cmd.tw     = 8'(8'(k_v) << (7 - int'(stage_ff)));
            unique case (sub_ff)
               3'd0:    cmd.op = OP_BF_RD;
               3'd1:    cmd.op = OP_BF_MUL;
               3'd2:    cmd.op = OP_BF_SUM;
               3'd3:    cmd.op = OP_BF_WA;
               default: cmd.op = OP_BF_WC;
            endcase
         end
         ST_OREAD: begin
            cmd.a_addr = ADDR_BITS'(a_out);
            cmd.c_addr = ADDR_BITS'(a_out | AW'(1));
            cmd.op     = sub_ff[0] ? OP_OUT_CAP : OP_OUT_RD;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         sub_ff     <= '0;
         cnt_ff     <= '0;
         stage_ff   <= '0;
         wp_ff      <= '0;
         fill_ff    <= '0;
         hop_ff     <= '0;
         hop_len_ff <= HOP_BITS'(128);
      end else begin
         if (csr_wr_en) hop_len_ff <= csr_wr_data;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  wp_ff   <= wp_ff + 1'b1;
                  fill_ff <= fill_in;
                  hop_ff  <= hop_in;
                  if (go) begin
                     state_ff <= ST_LOAD;
                     sub_ff   <= '0;
                     cnt_ff   <= '0;
                  end
               end
            end
            ST_LOAD: begin
               if (sub_ff == 3'd4) begin
                  sub_ff <= '0;
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == AW'(FRAME_POINTS - 1)) begin
                     state_ff <= ST_BFLY;
                     stage_ff <= '0;
                  end
               end else begin
                  sub_ff <= sub_ff + 1'b1;
               end
            end
            ST_BFLY: begin
               if (sub_ff == 3'd4) begin
                  sub_ff <= '0;
                  if (cnt_ff == AW'(FRAME_POINTS / 2 - 1)) begin
                     cnt_ff <= '0;
                     if (stage_ff == SW'(AW - 1)) state_ff <= ST_OREAD;
                     else stage_ff <= stage_ff + 1'b1;
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end else begin
                  sub_ff <= sub_ff + 1'b1;
               end
            end
            ST_OREAD: begin
               if (sub_ff == 3'(2 * PAIRS - 1)) begin
                  state_ff <= ST_OSHOW;
                  sub_ff   <= '0;
               end else begin
                  sub_ff <= sub_ff + 1'b1;
               end
            end
            default: begin
               if (rsp_ready) begin
                  if (cnt_ff == AW'(GROUPS - 1)) begin
                     state_ff <= ST_IDLE;
                     cnt_ff   <= '0;
                  end else begin
                     state_ff <= ST_OREAD;
                     cnt_ff   <= cnt_ff + 1'b1;
                  end
               end
            end
         endcase
      end
   end

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(state_ff == ST_IDLE) && state_ff == ST_LOAD |-> $past(req_valid))
      else $error("frame started without a transaction");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(FRAME_POINTS))
      else $error("fill count past frame length");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(cnt_ff))
      else $error("result group dropped");

endmodule

// ===== rtl/hamming_windowed_fft_frames.sv =====
// Top level of the Hamming-windowed FFT frame block.
// Depends on hwfft_pkg, hwfft_ctrl and hwfft_datapath.
//
// A sample transaction is accepted whenever no frame is in work. When a frame
// is due, the block stops taking samples and works it with one shared
// butterfly: first a windowing pass over every sample, then the butterflies
// (N/2*log2(N) of them, one at a time), then the result groups, each read
// out and held until rsp_ready.
// No clearing pass after reset.
module hamming_windowed_fft_frames import hwfft_pkg::*; #(
   parameter int FRAME_POINTS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_payload,
   input  logic                csr_wr_en,
   input  logic [HOP_BITS-1:0] csr_wr_data
);

   cmd_type cmd;

   hwfft_ctrl #(.FRAME_POINTS(FRAME_POINTS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_payload.restart),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd)
   );

   hwfft_datapath #(.FRAME_POINTS(FRAME_POINTS)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sample      (req_payload.sample),
      .rsp_payload (rsp_payload)
   );

endmodule
